// ===== rtl/ccps_pkg.sv =====
// Package for the corner cutting path smoother.
// Holds the transaction structs, widths, register indexes and reset values.
// No dependencies.
package ccps_pkg;

    localparam int MAX_LEVELS = 6;
    localparam int LVL_W      = 3;     // holds 0..MAX_LEVELS
    localparam int COORD_W    = 24;
    localparam int RATIO_W    = 16;
    localparam int CNT_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CUT_RATIO   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_COUNT = 1'b1;

    // Register reset values
    localparam logic [RATIO_W-1:0] CUT_RATIO_RST   = 16'd16384;
    localparam logic [CNT_W-1:0]   LEVEL_COUNT_RST = 3'd3;

    // Blend steps of one corner cut, issued in this order
    localparam logic [1:0] OP_QX = 2'd0;
    localparam logic [1:0] OP_QY = 2'd1;
    localparam logic [1:0] OP_RX = 2'd2;
    localparam logic [1:0] OP_RY = 2'd3;

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord point_x;
        t_coord point_y;
        logic   path_start;
    } t_point_in;

    typedef struct packed {
        t_coord out_x;
        t_coord out_y;
        logic   run_last;
    } t_point_out;

endpackage

// ===== rtl/ccps_blend.sv =====
// Shared blend unit: ((65536-a)*u + a*v) / 65536, rounded half up, saturated.
// Three-stage pipeline with one 17x25 multiplier: difference, scale by ratio, round and saturate.
// Depends on ccps_pkg.
module ccps_blend (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  ccps_pkg::t_coord        i_u,
    input  ccps_pkg::t_coord        i_v,
    input  logic [ccps_pkg::RATIO_W-1:0] i_ratio,
    output logic                    o_done,
    output ccps_pkg::t_coord        o_res
);
    import ccps_pkg::*;

    localparam int DIFF_W = COORD_W + 1;
    localparam int PROD_W = DIFF_W + RATIO_W + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int Q_W    = SUM_W - RATIO_W;

    logic                     r_v1;
    logic                     r_v2;
    logic                     r_done;
    logic signed [DIFF_W-1:0] r_diff;
    t_coord                   r_u1;
    t_coord                   r_u2;
    logic signed [PROD_W-1:0] r_prod;
    t_coord                   r_res;

    logic signed [SUM_W-1:0]  sum;
    logic signed [Q_W-1:0]    quo;
    t_coord                   sat;

    // Round half up and saturate
    always_comb begin
        sum = (SUM_W'(r_u2) <<< RATIO_W) + SUM_W'(r_prod)
              + SUM_W'(signed'({1'b0, 16'h8000}));
        quo = sum[SUM_W-1:RATIO_W];
        if (quo > Q_W'(signed'(24'sh7FFFFF))) begin
            sat = 24'sh7FFFFF;
        end else if (quo < Q_W'(signed'(24'sh800000))) begin
            sat = 24'sh800000;
        end else begin
            sat = quo[COORD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
        // stage 1: difference
        if (i_start) begin
            r_diff <= DIFF_W'(i_v) - DIFF_W'(i_u);
            r_u1   <= i_u;
        end
        // stage 2: scale by ratio
        if (r_v1) begin
            r_prod <= PROD_W'(signed'({1'b0, i_ratio})) * PROD_W'(r_diff);
            r_u2   <= r_u1;
        end
        // stage 3: round and saturate
        if (r_v2) begin
            r_res <= sat;
        end
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

// ===== rtl/corner_cutting_path_smoother.sv =====
// Corner cutting (Chaikin) path smoother, streaming, depth first over levels.
// Each corner cut is one level step plus four blends, issued one at a time through
// the shared three-stage multiplier unit; the results then leave one by one.
// Throughput: one point at a time; ready only while idle, so a point at six levels
// (63 cuts, 64 results) is worked through in full before the next point is taken.
// Reset (synchronous, active low) clears all level history and restores the registers.
module corner_cutting_path_smoother (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  ccps_pkg::t_point_in             i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output ccps_pkg::t_point_out            o_out_data,
    input  logic                            i_cfg_we,
    input  logic [ccps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ccps_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import ccps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FEED,
        ST_CALC,
        ST_EMIT,
        ST_POP,
        ST_FLUSH
    } t_state;

    t_state               r_state;
    logic [RATIO_W-1:0]   r_cut_ratio;
    logic [CNT_W-1:0]     r_level_count;
    logic [LVL_W-1:0]     r_levels;
    logic [LVL_W-1:0]     r_lvl;
    t_coord               r_cur_x;
    t_coord               r_cur_y;

    // per-level history and pending second point
    t_coord               r_prev_x [MAX_LEVELS];
    t_coord               r_prev_y [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] r_prev_valid;
    t_coord               r_pend_x [MAX_LEVELS];
    t_coord               r_pend_y [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] r_pend_valid;

    // blend sequencing: qx, qy, rx, ry in turn
    logic [1:0]           r_op;
    logic                 r_issued;
    t_coord               r_qx;
    t_coord               r_qy;
    t_coord               r_rx;

    // one-result hold so the final result can carry run_last
    logic                 r_hold_v;
    t_coord               r_hold_x;
    t_coord               r_hold_y;
    logic                 r_out_v;
    t_point_out           r_out;

    logic                 blend_start;
    t_coord               blend_u;
    t_coord               blend_v;
    logic                 blend_done;
    t_coord               blend_res;
    logic                 out_free;
    logic                 out_load;
    logic                 pop_found;
    logic [LVL_W-1:0]     pop_idx;
    t_coord               lvl_px;
    t_coord               lvl_py;

    assign lvl_px = r_prev_x[r_lvl];
    assign lvl_py = r_prev_y[r_lvl];

    // operand select for the shared blend unit
    always_comb begin
        case (r_op)
            OP_QX:   begin blend_u = lvl_px;  blend_v = r_cur_x; end
            OP_QY:   begin blend_u = lvl_py;  blend_v = r_cur_y; end
            OP_RX:   begin blend_u = r_cur_x; blend_v = lvl_px;  end
            default: begin blend_u = r_cur_y; blend_v = lvl_py;  end
        endcase
    end

    assign blend_start = (r_state == ST_CALC) && !r_issued;

    ccps_blend u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_start),
        .i_u     (blend_u),
        .i_v     (blend_v),
        .i_ratio (r_cut_ratio),
        .o_done  (blend_done),
        .o_res   (blend_res)
    );

    // deepest level with a pending second point
    always_comb begin
        pop_found = 1'b0;
        pop_idx   = '0;
        for (int i = 0; i < MAX_LEVELS; i++) begin
            if (r_pend_valid[i]) begin
                pop_found = 1'b1;
                pop_idx   = LVL_W'(i);
            end
        end
    end

    assign out_free    = !r_out_v || i_out_ready;
    // output register takes a new result this cycle
    assign out_load    = ((r_state == ST_EMIT) || (r_state == ST_FLUSH)) &&
                         r_hold_v && out_free;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cut_ratio   <= CUT_RATIO_RST;
            r_level_count <= LEVEL_COUNT_RST;
            r_prev_valid  <= '0;
            r_pend_valid  <= '0;
            r_issued      <= 1'b0;
            r_op          <= OP_QX;
            r_hold_v      <= 1'b0;
            r_out_v       <= 1'b0;
            r_levels      <= '0;
            r_lvl         <= '0;
        end else begin
            if (r_out_v && i_out_ready && !out_load) begin
                r_out_v <= 1'b0;
            end

            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_CUT_RATIO:   r_cut_ratio   <= i_cfg_data[RATIO_W-1:0];
                    CFG_LEVEL_COUNT: r_level_count <= i_cfg_data[CNT_W-1:0];
                    default:         ;
                endcase
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_cur_x  <= i_in_data.point_x;
                        r_cur_y  <= i_in_data.point_y;
                        r_lvl    <= '0;
                        r_levels <= (r_level_count > CNT_W'(MAX_LEVELS)) ?
                                    LVL_W'(MAX_LEVELS) : LVL_W'(r_level_count);
                        if (i_in_data.path_start) begin
                            r_prev_valid <= '0;
                        end
                        r_state  <= ST_FEED;
                    end
                end

                ST_FEED: begin
                    if (r_lvl >= r_levels) begin
                        r_state <= ST_EMIT;
                    end else if (!r_prev_valid[r_lvl]) begin
                        r_prev_x[r_lvl]     <= r_cur_x;
                        r_prev_y[r_lvl]     <= r_cur_y;
                        r_prev_valid[r_lvl] <= 1'b1;
                        r_state             <= ST_POP;
                    end else begin
                        r_op     <= OP_QX;
                        r_issued <= 1'b0;
                        r_state  <= ST_CALC;
                    end
                end

                ST_CALC: begin
                    if (blend_start) begin
                        r_issued <= 1'b1;
                    end
                    if (blend_done) begin
                        r_issued <= 1'b0;
                        r_op     <= r_op + 2'd1;
                        case (r_op)
                            OP_QX: r_qx <= blend_res;
                            OP_QY: r_qy <= blend_res;
                            OP_RX: r_rx <= blend_res;
                            default: begin
                                // cut done: stash r, keep p, send q down
                                r_pend_x[r_lvl]     <= r_rx;
                                r_pend_y[r_lvl]     <= blend_res;
                                r_pend_valid[r_lvl] <= 1'b1;
                                r_prev_x[r_lvl]     <= r_cur_x;
                                r_prev_y[r_lvl]     <= r_cur_y;
                                r_cur_x             <= r_qx;
                                r_cur_y             <= r_qy;
                                r_lvl               <= r_lvl + LVL_W'(1);
                                r_state             <= ST_FEED;
                            end
                        endcase
                    end
                end

                ST_EMIT: begin
                    if (!r_hold_v) begin
                        r_hold_x <= r_cur_x;
                        r_hold_y <= r_cur_y;
                        r_hold_v <= 1'b1;
                        r_state  <= ST_POP;
                    end else if (out_free) begin
                        r_out.out_x    <= r_hold_x;
                        r_out.out_y    <= r_hold_y;
                        r_out.run_last <= 1'b0;
                        r_out_v        <= 1'b1;
                        r_hold_x       <= r_cur_x;
                        r_hold_y       <= r_cur_y;
                        r_state        <= ST_POP;
                    end
                end

                ST_POP: begin
                    if (pop_found) begin
                        r_cur_x               <= r_pend_x[pop_idx];
                        r_cur_y               <= r_pend_y[pop_idx];
                        r_pend_valid[pop_idx] <= 1'b0;
                        r_lvl                 <= pop_idx + LVL_W'(1);
                        r_state               <= ST_FEED;
                    end else begin
                        r_state <= ST_FLUSH;
                    end
                end

                ST_FLUSH: begin
                    if (!r_hold_v) begin
                        r_state <= ST_IDLE;
                    end else if (out_free) begin
                        r_out.out_x    <= r_hold_x;
                        r_out.out_y    <= r_hold_y;
                        r_out.run_last <= 1'b1;
                        r_out_v        <= 1'b1;
                        r_hold_v       <= 1'b0;
                        r_state        <= ST_IDLE;
                    end
                end

                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

// ===== sim/ccps_check.sv =====
// Checker for the corner cutting path smoother: watches both channels and the
// register port, predicts each smoothed point and compares it with the output.
// Depends on ccps_pkg.
`timescale 1ns / 1ps

module ccps_check (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  ccps_pkg::t_point_in             i_in_data,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  ccps_pkg::t_point_out            i_out_data,
    input  logic                            i_cfg_we,
    input  logic [ccps_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ccps_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output int                              o_pending,
    output int                              o_fail_count
);
    import ccps_pkg::*;

    // Shadow registers and per-level history
    logic [RATIO_W-1:0]    ratio_now;
    logic [CNT_W-1:0]      depth_now;
    t_coord                hist_x [MAX_LEVELS];
    t_coord                hist_y [MAX_LEVELS];
    logic [MAX_LEVELS-1:0] hist_valid;

    t_point_out smoothed_q[$];
    t_point_out want;
    int         fails = 0;

    // ((1-a)*u + a*v), Q0.16 weight, round half up, saturate to 24 bits
    function automatic t_coord weigh(t_coord u, t_coord v, logic [RATIO_W-1:0] a);
        longint n;
        n = (64'sd65536 - longint'(a)) * longint'(u) + longint'(a) * longint'(v);
        n = (n + 64'sd32768) >>> 16;
        if (n > 64'sd8388607)
            n = 64'sd8388607;
        else if (n < -64'sd8388608)
            n = -64'sd8388608;
        return n[COORD_W-1:0];
    endfunction

    // Push one point through the levels depth first; queue the points that leave
    function automatic void cut_corners(t_point_in p);
        int         depth;
        int         sp;
        int         lv [16];
        t_coord     sx [16];
        t_coord     sy [16];
        int         cur;
        t_coord     cx, cy, qx, qy, rx, ry;
        logic       have_res;
        t_point_out held;

        depth    = (int'(depth_now) > MAX_LEVELS) ? MAX_LEVELS : int'(depth_now);
        have_res = 1'b0;
        held     = '0;
        if (p.path_start)
            hist_valid = '0;

        sp    = 1;
        lv[0] = 0;
        sx[0] = p.point_x;
        sy[0] = p.point_y;
        while (sp > 0) begin
            sp--;
            cur = lv[sp];
            cx  = sx[sp];
            cy  = sy[sp];
            if (cur >= depth) begin
                // leaves the last level: a result; hold it so run_last can be set
                if (have_res)
                    smoothed_q = {smoothed_q, held};
                held.out_x    = cx;
                held.out_y    = cy;
                held.run_last = 1'b0;
                have_res      = 1'b1;
            end else if (!hist_valid[cur]) begin
                hist_x[cur]     = cx;
                hist_y[cur]     = cy;
                hist_valid[cur] = 1'b1;
            end else begin
                qx = weigh(hist_x[cur], cx, ratio_now);
                qy = weigh(hist_y[cur], cy, ratio_now);
                rx = weigh(cx, hist_x[cur], ratio_now);
                ry = weigh(cy, hist_y[cur], ratio_now);
                hist_x[cur] = cx;
                hist_y[cur] = cy;
                // r below q on the stack so q's subtree goes out first
                lv[sp]   = cur + 1;
                sx[sp]   = rx;
                sy[sp]   = ry;
                lv[sp+1] = cur + 1;
                sx[sp+1] = qx;
                sy[sp+1] = qy;
                sp += 2;
            end
        end
        if (have_res) begin
            held.run_last = 1'b1;
            smoothed_q    = {smoothed_q, held};
        end
    endfunction

    // Sample every transaction at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            ratio_now  = CUT_RATIO_RST;
            depth_now  = LEVEL_COUNT_RST;
            hist_valid = '0;
            for (int i = 0; i < MAX_LEVELS; i++) begin
                hist_x[i] = '0;
                hist_y[i] = '0;
            end
            smoothed_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_CUT_RATIO)
                    ratio_now = i_cfg_data[RATIO_W-1:0];
                else if (i_cfg_index == CFG_LEVEL_COUNT)
                    depth_now = i_cfg_data[CNT_W-1:0];
            end

            // output side first: a result never belongs to a point taken this edge
            if (i_out_valid && i_out_ready) begin
                if (smoothed_q.size() == 0) begin
                    $error("unexpected result: out_x=%0d out_y=%0d run_last=%0b",
                           i_out_data.out_x, i_out_data.out_y, i_out_data.run_last);
                    fails++;
                end else begin
                    want = smoothed_q.pop_front();
                    if (i_out_data.out_x !== want.out_x) begin
                        $error("out_x: expected %0d, actual %0d", want.out_x, i_out_data.out_x);
                        fails++;
                    end
                    if (i_out_data.out_y !== want.out_y) begin
                        $error("out_y: expected %0d, actual %0d", want.out_y, i_out_data.out_y);
                        fails++;
                    end
                    if (i_out_data.run_last !== want.run_last) begin
                        $error("run_last: expected %0b, actual %0b",
                               want.run_last, i_out_data.run_last);
                        fails++;
                    end
                end
            end

            if (i_in_valid && i_in_ready)
                cut_corners(i_in_data);
        end
        o_pending    <= smoothed_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== sim/tb.sv =====
// Top of the corner cutting path smoother testbench: clock, reset, stimulus,
// register writes, output stalls and the verdict. Depends on ccps_pkg,
// corner_cutting_path_smoother and ccps_check.
`timescale 1ns / 1ps

module tb;
    import ccps_pkg::*;

    localparam int     PHASE_ITEMS   = 25;
    localparam int     SETTLE_CYCLES = 1500;
    localparam int     HOLD_CYCLES   = 3000;
    localparam int     CYCLE_LIMIT   = 2000000;
    localparam t_coord C_MAX         = 24'h7FFFFF;
    localparam t_coord C_MIN         = 24'h800000;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_ready;
    t_point_in             in_data   = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    t_point_out            out_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  hold_req  = 1'b0;

    int pending;
    int fail_count;
    int burst_left = 0;

    corner_cutting_path_smoother dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ccps_check checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_we     (cfg_we),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial begin
        int unsigned cyc;
        cyc = 0;
        while (cyc < CYCLE_LIMIT) begin
            @(posedge clk);
            cyc++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Receiver: changing stall patterns, plus one long hold-off on request
    initial begin
        int   mode;
        int   mode_left;
        logic held;
        mode      = 0;
        mode_left = 0;
        held      = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_req && !held) begin
                held = 1'b1;
                out_ready <= 1'b0;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0:       out_ready <= 1'b1;
                1:       out_ready <= ($urandom_range(0, 3) != 0);
                2:       out_ready <= ($urandom_range(0, 3) == 0);
                default: out_ready <= ((mode_left % 6) > 2);
            endcase
        end
    end

    // Offer one point; bursts of random length separated by random gaps
    task automatic offer_point(input t_coord x, input t_coord y, input logic start);
        int        gap;
        t_point_in p;
        p.point_x    = x;
        p.point_y    = y;
        p.path_start = start;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= p;
        do @(posedge clk); while (!in_ready);
    endtask

    // Stop offering and wait for every expected point plus the block's tail
    task automatic settle();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers; only called while the block is idle
    task automatic set_config(input logic [RATIO_W-1:0] ratio, input logic [CNT_W-1:0] lv);
        logic [CFG_DATA_W-1:0] lv_word;
        lv_word            = 16'($urandom);
        lv_word[CNT_W-1:0] = lv;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_CUT_RATIO;
        cfg_data  <= ratio;
        @(posedge clk);
        cfg_index <= CFG_LEVEL_COUNT;
        cfg_data  <= lv_word;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Next coordinate: often a walk from the last one, else random, small or extreme
    function automatic t_coord pick_coord(t_coord prev);
        logic [31:0] r;
        int          sel;
        r   = $urandom;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return prev + t_coord'(r[12:0]) - t_coord'(24'd4096);
        else if (sel < 7)
            return r[COORD_W-1:0];
        else if (sel == 7)
            return r[31] ? C_MAX : C_MIN;
        else
            return t_coord'(r[9:0]) - t_coord'(24'd512);
    endfunction

    // Stimulus and verdict
    initial begin
        t_coord x, y;
        int     left, plen, kind;
        logic   start;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings (ratio 0.25, three levels); short paths of one to four points
        offer_point(24'sd0, 24'sd0, 1'b1);
        offer_point(C_MAX, C_MAX, 1'b0);
        offer_point(C_MIN, C_MIN, 1'b0);
        offer_point(C_MAX, C_MIN, 1'b0);
        offer_point(-24'sd1, 24'sd1, 1'b1);
        offer_point(24'sd256, -24'sd256, 1'b1);
        offer_point(24'sd512, 24'sd0, 1'b0);
        settle();

        // zero levels: straight pass-through
        set_config(16'h0000, 3'd0);
        offer_point(C_MIN, C_MAX, 1'b1);
        offer_point(C_MAX, C_MIN, 1'b0);
        settle();

        // level count above the bound, ratio at its top
        set_config(16'hFFFF, 3'd7);
        offer_point(24'sd0, 24'sd0, 1'b1);
        offer_point(C_MAX, 24'sd0, 1'b0);
        offer_point(24'sd0, C_MIN, 1'b0);
        settle();

        // ratio zero: q is p1 and r is p2
        set_config(16'h0000, 3'd2);
        offer_point(24'sd100, 24'sd200, 1'b1);
        offer_point(-24'sd300, 24'sd50, 1'b0);
        offer_point(24'sd7, -24'sd9, 1'b0);
        settle();

        // half ratio on odd steps exercises ties in rounding
        set_config(16'h8000, 3'd4);
        offer_point(24'sd1, 24'sd1, 1'b1);
        offer_point(24'sd2, -24'sd2, 1'b0);
        offer_point(-24'sd3, 24'sd3, 1'b0);
        settle();

        // level count changed mid path; deeper levels keep stale history
        set_config(16'h8000, 3'd1);
        offer_point(24'sd4, 24'sd5, 1'b0);
        offer_point(-24'sd1, 24'sd0, 1'b0);
        settle();
        set_config(16'h8000, 3'd5);
        offer_point(C_MIN, C_MAX, 1'b0);
        offer_point(C_MAX, C_MIN, 1'b0);

        // random paths under a series of settings
        x = '0;
        y = '0;
        for (int ph = 0; ph < 8; ph++) begin
            settle();
            case (ph)
                0:       set_config(16'($urandom), 3'd2);
                1:       set_config(16'h0001, 3'd5);
                2:       set_config(16'hFFFF, 3'd1);
                3:       set_config(16'($urandom), 3'd7);
                4:       set_config(16'h8000, 3'd3);
                5:       set_config(16'h0000, 3'd0);
                6:       set_config(16'($urandom), 3'd4);
                default: set_config(16'hC000, 3'd6);
            endcase
            if (ph == 6)
                hold_req <= 1'b1;
            left = PHASE_ITEMS;
            while (left > 0) begin
                plen = $urandom_range(2, 12);
                kind = $urandom_range(0, 9);
                for (int k = 0; k < plen && left > 0; k++) begin
                    // most paths open with a start flag; stray flags mid path are noise
                    if (k == 0)
                        start = (kind != 0);
                    else
                        start = ($urandom_range(0, 19) == 0);
                    x = pick_coord(x);
                    y = pick_coord(y);
                    offer_point(x, y, start);
                    left--;
                end
            end
        end
        settle();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/ccps_pkg.sv
rtl/ccps_blend.sv
rtl/corner_cutting_path_smoother.sv
sim/ccps_check.sv
sim/tb.sv
